// File: rtl/ipsp_pkg.sv
// Shared types, codes and reset constants for the idle power state policy block.
package ipsp_pkg;

  localparam int unsigned BLOCKER_BITS_DEF = 8;
  localparam int unsigned MASK_W           = 8;
  localparam int unsigned TIME_W           = 32;
  localparam int unsigned CFG_IDX_W        = 3;

  localparam logic [TIME_W-1:0] AUDIO_IDLE_RST     = 32'd5000;
  localparam logic [TIME_W-1:0] CONN_IDLE_RST      = 32'd30000;
  localparam logic [TIME_W-1:0] DISC_IDLE_RST      = 32'd30000;
  localparam logic [TIME_W-1:0] OVERNIGHT_SLEEP_RST = 32'd1800000;

  typedef enum logic [2:0] {
    OP_EVAL      = 3'd0,
    OP_ACTIVITY  = 3'd1,
    OP_SET_BLK   = 3'd2,
    OP_CLR_BLK   = 3'd3,
    OP_LINK      = 3'd4,
    OP_SLEEP_REQ = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    MODE_ACTIVE    = 2'd0,
    MODE_CONN_IDLE = 2'd1,
    MODE_DISC_IDLE = 2'd2,
    MODE_OVERNIGHT = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REJ_NONE     = 3'd0,
    REJ_BLOCKERS = 3'd1,
    REJ_AUDIO    = 3'd2,
    REJ_NO_WAKE  = 3'd3,
    REJ_DISABLED = 3'd4
  } reject_e;

  typedef enum logic [1:0] {
    REASON_NONE      = 2'd0,
    REASON_OVERNIGHT = 2'd1,
    REASON_MANUAL    = 2'd2
  } reason_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVERNIGHT_EN  = 3'd0,
    CFG_AUDIO_IDLE    = 3'd1,
    CFG_CONN_IDLE     = 3'd2,
    CFG_DISC_IDLE     = 3'd3,
    CFG_OVERNIGHT_MS  = 3'd4,
    CFG_WAKE_PIN_OK   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic              overnight_enable;
    logic [TIME_W-1:0] audio_thr_ms;
    logic [TIME_W-1:0] conn_thr_ms;
    logic [TIME_W-1:0] disc_thr_ms;
    logic [TIME_W-1:0] night_thr_ms;
    logic              wake_pin_ok;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [TIME_W-1:0] now_ms;
    logic [MASK_W-1:0] blk_mask;
    logic              link_connected;
    logic              audio_session_active;
  } in_item_t;

  typedef struct packed {
    mode_e             power_state;
    logic              state_changed;
    logic [TIME_W-1:0] idle_ms;
    logic              audio_power_save;
    logic              low_power_mode;
    logic              low_power_advertising;
    logic              sleep_entered;
    logic [2:0]        reject_cause;
  } result_t;

  // Policy state apart from the blocker set, whose width is a parameter.
  typedef struct packed {
    mode_e             mode;
    logic [TIME_W-1:0] last_activity;
    logic              link_up;
    logic              audio_save_on;
    logic              low_power_on;
    logic              advertise_low;
    logic [TIME_W-1:0] sleep_count;
    reason_e           sleep_why;
  } pstate_t;

endpackage

// File: rtl/ipsp_cfg_regs.sv
// Configuration register file with write port and reset defaults.
module ipsp_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ipsp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ipsp_pkg::TIME_W-1:0]      cfg_data_i,
  output ipsp_pkg::cfg_t                   cfg_o
);

  ipsp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ipsp_pkg::CFG_OVERNIGHT_EN: cfg_d.overnight_enable = cfg_data_i[0];
        ipsp_pkg::CFG_AUDIO_IDLE:   cfg_d.audio_thr_ms     = cfg_data_i;
        ipsp_pkg::CFG_CONN_IDLE:    cfg_d.conn_thr_ms      = cfg_data_i;
        ipsp_pkg::CFG_DISC_IDLE:    cfg_d.disc_thr_ms      = cfg_data_i;
        ipsp_pkg::CFG_OVERNIGHT_MS: cfg_d.night_thr_ms     = cfg_data_i;
        ipsp_pkg::CFG_WAKE_PIN_OK:  cfg_d.wake_pin_ok      = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.overnight_enable <= 1'b1;
      cfg_q.audio_thr_ms     <= ipsp_pkg::AUDIO_IDLE_RST;
      cfg_q.conn_thr_ms      <= ipsp_pkg::CONN_IDLE_RST;
      cfg_q.disc_thr_ms      <= ipsp_pkg::DISC_IDLE_RST;
      cfg_q.night_thr_ms     <= ipsp_pkg::OVERNIGHT_SLEEP_RST;
      cfg_q.wake_pin_ok      <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/ipsp_step.sv
// Next-state and result logic for one event of the power policy.
module ipsp_step #(
  parameter int unsigned BLOCKER_BITS = ipsp_pkg::BLOCKER_BITS_DEF
) (
  input  ipsp_pkg::in_item_t       item_i,
  input  ipsp_pkg::cfg_t           cfg_i,
  input  ipsp_pkg::pstate_t        st_i,
  input  logic [BLOCKER_BITS-1:0]  blk_i,
  output ipsp_pkg::pstate_t        st_o,
  output logic [BLOCKER_BITS-1:0]  blk_o,
  output ipsp_pkg::result_t        res_o
);

  function automatic ipsp_pkg::reject_e sleep_check(input logic en, input logic blocked,
                                                    input logic audio, input logic wake);
    ipsp_pkg::reject_e r;
    if (!en) r = ipsp_pkg::REJ_DISABLED;
    else if (blocked) r = ipsp_pkg::REJ_BLOCKERS;
    else if (audio) r = ipsp_pkg::REJ_AUDIO;
    else if (!wake) r = ipsp_pkg::REJ_NO_WAKE;
    else r = ipsp_pkg::REJ_NONE;
    return r;
  endfunction

  logic [BLOCKER_BITS-1:0]     mask;
  logic [BLOCKER_BITS-1:0]     blk_n;
  logic [ipsp_pkg::TIME_W-1:0] la_mid;
  logic [ipsp_pkg::TIME_W-1:0] idle;
  logic                        link_chg;
  logic                        lu_mid;
  ipsp_pkg::mode_e             target;
  ipsp_pkg::reject_e           rej;
  ipsp_pkg::reject_e           cause;
  ipsp_pkg::pstate_t           s;
  logic                        entered;

  // Fit the fixed-width mask field onto the blocker set.
  always_comb begin
    for (int i = 0; i < BLOCKER_BITS; i++) begin
      mask[i] = (i < ipsp_pkg::MASK_W) ? item_i.blk_mask[i % ipsp_pkg::MASK_W] : 1'b0;
    end
  end

  // Evaluate path: link change restarts the idle timer before the target is picked.
  assign link_chg = (st_i.link_up != item_i.link_connected);
  assign lu_mid   = item_i.link_connected;
  assign la_mid   = link_chg ? item_i.now_ms : st_i.last_activity;
  assign idle     = item_i.now_ms - la_mid;

  always_comb begin
    if (blk_i != '0) begin
      target = ipsp_pkg::MODE_ACTIVE;
    end else if (cfg_i.overnight_enable && idle >= cfg_i.night_thr_ms) begin
      target = ipsp_pkg::MODE_OVERNIGHT;
    end else if (lu_mid) begin
      target = (idle >= cfg_i.conn_thr_ms) ? ipsp_pkg::MODE_CONN_IDLE
                                           : ipsp_pkg::MODE_ACTIVE;
    end else begin
      target = (idle >= cfg_i.disc_thr_ms) ? ipsp_pkg::MODE_DISC_IDLE
                                           : ipsp_pkg::MODE_ACTIVE;
    end
  end

  assign rej = sleep_check(cfg_i.overnight_enable, blk_i != '0,
                           item_i.audio_session_active, cfg_i.wake_pin_ok);

  always_comb begin
    s       = st_i;
    blk_n   = blk_i;
    entered = 1'b0;
    cause   = ipsp_pkg::REJ_NONE;
    case (item_i.opcode)
      ipsp_pkg::OP_EVAL: begin
        if (link_chg) begin
          s.link_up       = lu_mid;
          s.last_activity = la_mid;
          s.mode          = ipsp_pkg::MODE_ACTIVE;
        end
        if (st_i.mode != target) begin
          s.mode          = target;
          s.audio_save_on = (target != ipsp_pkg::MODE_ACTIVE);
          s.low_power_on  = (target != ipsp_pkg::MODE_ACTIVE);
          s.advertise_low = (target == ipsp_pkg::MODE_DISC_IDLE) ||
                            (target == ipsp_pkg::MODE_OVERNIGHT);
        end
        if (target == ipsp_pkg::MODE_ACTIVE) begin
          s.audio_save_on = (blk_i == '0) && (idle >= cfg_i.audio_thr_ms);
        end
        if (target == ipsp_pkg::MODE_OVERNIGHT) begin
          cause = rej;
          if (rej != ipsp_pkg::REJ_NONE) begin
            // Drop back to idle and restart the timer.
            s.last_activity = item_i.now_ms;
            s.mode = lu_mid ? ipsp_pkg::MODE_CONN_IDLE : ipsp_pkg::MODE_DISC_IDLE;
          end else begin
            entered       = 1'b1;
            s.sleep_count = st_i.sleep_count + 1'b1;
            s.sleep_why   = ipsp_pkg::REASON_OVERNIGHT;
          end
        end
      end
      ipsp_pkg::OP_ACTIVITY, ipsp_pkg::OP_SLEEP_REQ: begin
        s.last_activity = item_i.now_ms;
        s.mode          = ipsp_pkg::MODE_ACTIVE;
        s.audio_save_on = 1'b0;
        if (st_i.mode != ipsp_pkg::MODE_ACTIVE) begin
          s.low_power_on  = 1'b0;
          s.advertise_low = 1'b0;
        end
        if (item_i.opcode == ipsp_pkg::OP_SLEEP_REQ) begin
          cause = rej;
          if (rej == ipsp_pkg::REJ_NONE) begin
            entered       = 1'b1;
            s.sleep_count = st_i.sleep_count + 1'b1;
            s.sleep_why   = ipsp_pkg::REASON_MANUAL;
          end
        end
      end
      ipsp_pkg::OP_SET_BLK, ipsp_pkg::OP_CLR_BLK: begin
        if (mask != '0) begin
          blk_n = (item_i.opcode == ipsp_pkg::OP_SET_BLK) ? (blk_i | mask) : (blk_i & ~mask);
          s.last_activity = item_i.now_ms;
          if (blk_n != '0) begin
            s.mode          = ipsp_pkg::MODE_ACTIVE;
            s.audio_save_on = 1'b0;
            if (st_i.mode != ipsp_pkg::MODE_ACTIVE) begin
              s.low_power_on  = 1'b0;
              s.advertise_low = 1'b0;
            end
          end
        end
      end
      ipsp_pkg::OP_LINK: begin
        s.link_up       = item_i.link_connected;
        s.last_activity = item_i.now_ms;
        s.mode          = ipsp_pkg::MODE_ACTIVE;
        s.audio_save_on = 1'b0;
        s.low_power_on  = 1'b0;
        s.advertise_low = 1'b0;
      end
      default: ;
    endcase
  end

  assign st_o  = s;
  assign blk_o = blk_n;

  assign res_o.power_state           = s.mode;
  assign res_o.state_changed         = (s.mode != st_i.mode);
  assign res_o.idle_ms               = item_i.now_ms - s.last_activity;
  assign res_o.audio_power_save      = s.audio_save_on;
  assign res_o.low_power_mode        = s.low_power_on;
  assign res_o.low_power_advertising = s.advertise_low;
  assign res_o.sleep_entered         = entered;
  assign res_o.reject_cause          = cause;

endmodule

// File: rtl/idle_power_state_policy.sv
// Idle power state policy: input register, event logic, policy state and result register.
// Path: an accepted item waits in the input register; the step loads its result into the result
// register, whose valid bit drives out_valid_o.
// Throughput: one item per cycle while out_stall_i is low; the result register frees as it is taken,
// so an item is accepted while a result waits, and in_stall_o rises only when the input register
// is full and the result register holds a stalled result.
// Reset: asynchronous, active low; policy state clears, configuration registers take their defaults.
module idle_power_state_policy #(
  parameter int unsigned BLOCKER_BITS = ipsp_pkg::BLOCKER_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ipsp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ipsp_pkg::TIME_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        opcode_i,
  input  logic [ipsp_pkg::TIME_W-1:0]       now_ms_i,
  input  logic [ipsp_pkg::MASK_W-1:0]       blk_mask_i,
  input  logic                              link_connected_i,
  input  logic                              audio_session_active_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        power_state_o,
  output logic                              state_changed_o,
  output logic [ipsp_pkg::TIME_W-1:0]       idle_ms_o,
  output logic                              audio_power_save_o,
  output logic                              low_power_mode_o,
  output logic                              low_power_advertising_o,
  output logic                              sleep_entered_o,
  output logic [2:0]                        reject_cause_o
);

  ipsp_pkg::cfg_t            cfg;
  ipsp_pkg::in_item_t        item_q;
  logic                      item_vld_q;
  ipsp_pkg::pstate_t         st_q, st_d;
  logic [BLOCKER_BITS-1:0]   blk_q, blk_d;
  ipsp_pkg::result_t         res_d, res_q;
  logic                      res_vld_q;
  logic                      res_ready;
  logic                      step_go;
  logic                      in_take;

  ipsp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ipsp_step #(.BLOCKER_BITS(BLOCKER_BITS)) u_step (
    .item_i (item_q),
    .cfg_i  (cfg),
    .st_i   (st_q),
    .blk_i  (blk_q),
    .st_o   (st_d),
    .blk_o  (blk_d),
    .res_o  (res_d)
  );

  assign res_ready  = !res_vld_q || !out_stall_i;
  assign step_go    = item_vld_q && res_ready;
  assign in_stall_o = item_vld_q && !res_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      blk_q      <= '0;
      st_q.mode          <= ipsp_pkg::MODE_ACTIVE;
      st_q.last_activity <= '0;
      st_q.link_up       <= 1'b0;
      st_q.audio_save_on <= 1'b0;
      st_q.low_power_on  <= 1'b0;
      st_q.advertise_low <= 1'b0;
      st_q.sleep_count   <= '0;
      st_q.sleep_why     <= ipsp_pkg::REASON_NONE;
    end else begin
      if (in_take) begin
        item_vld_q <= 1'b1;
      end else if (step_go) begin
        item_vld_q <= 1'b0;
      end
      if (step_go) begin
        res_vld_q <= 1'b1;
        st_q      <= st_d;
        blk_q     <= blk_d;
      end else if (!out_stall_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: load the item on accept, the result when the step fires.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.opcode               <= opcode_i;
      item_q.now_ms               <= now_ms_i;
      item_q.blk_mask             <= blk_mask_i;
      item_q.link_connected       <= link_connected_i;
      item_q.audio_session_active <= audio_session_active_i;
    end
    if (step_go) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o             = res_vld_q;
  assign power_state_o           = res_q.power_state;
  assign state_changed_o         = res_q.state_changed;
  assign idle_ms_o               = res_q.idle_ms;
  assign audio_power_save_o      = res_q.audio_power_save;
  assign low_power_mode_o        = res_q.low_power_mode;
  assign low_power_advertising_o = res_q.low_power_advertising;
  assign sleep_entered_o         = res_q.sleep_entered;
  assign reject_cause_o          = res_q.reject_cause;

endmodule

// File: rtl/ipsp_checker.sv
// Port-level checks for the idle power state policy, bound to the top level.
module ipsp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [1:0]                     power_state_o,
  input logic [ipsp_pkg::TIME_W-1:0]    idle_ms_o,
  input logic                           sleep_entered_o,
  input logic [2:0]                     reject_cause_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(power_state_o) &&
      $stable(idle_ms_o) && $stable(reject_cause_o))
    else $error("stalled result changed");

  // An entered sleep carries no refusal and leaves the mode active or overnight.
  a_sleep_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sleep_entered_o |->
      reject_cause_o == ipsp_pkg::REJ_NONE &&
      (power_state_o == ipsp_pkg::MODE_ACTIVE || power_state_o == ipsp_pkg::MODE_OVERNIGHT))
    else $error("sleep entry with refusal or wrong mode");

  // A refusal code is always one of the defined causes.
  a_cause_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> reject_cause_o == ipsp_pkg::REJ_NONE ||
      reject_cause_o == ipsp_pkg::REJ_BLOCKERS || reject_cause_o == ipsp_pkg::REJ_AUDIO ||
      reject_cause_o == ipsp_pkg::REJ_NO_WAKE || reject_cause_o == ipsp_pkg::REJ_DISABLED)
    else $error("undefined reject cause");

  // With no result waiting the input side never stalls.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // Once the result side is free, an accepted item shows a result after the input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("result missing after accept");

endmodule

bind idle_power_state_policy ipsp_checker u_ipsp_checker (.*);

// File: test/tb_idle_power_state_policy.sv
// Self-checking testbench for the idle power state policy block with a built-in event predictor.
module tb_idle_power_state_policy;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  // Tracks the policy state and queues the result each accepted item should produce.
  class policy_tracker;
    ipsp_pkg::result_t expected_results[$];
    int errors;

    logic                        guard_en;
    logic                        wake_ok;
    logic [ipsp_pkg::TIME_W-1:0] audio_thr;
    logic [ipsp_pkg::TIME_W-1:0] conn_thr;
    logic [ipsp_pkg::TIME_W-1:0] disc_thr;
    logic [ipsp_pkg::TIME_W-1:0] night_thr;

    ipsp_pkg::mode_e             mode;
    logic [ipsp_pkg::MASK_W-1:0] blockers;
    logic [ipsp_pkg::TIME_W-1:0] last_act;
    logic                        link_up;
    logic                        audio_save;
    logic                        low_power;
    logic                        adv_low;
    logic [ipsp_pkg::TIME_W-1:0] sleep_cnt;
    ipsp_pkg::reason_e           last_reason;

    function new();
      errors      = 0;
      guard_en    = 1'b1;
      wake_ok     = 1'b1;
      audio_thr   = ipsp_pkg::AUDIO_IDLE_RST;
      conn_thr    = ipsp_pkg::CONN_IDLE_RST;
      disc_thr    = ipsp_pkg::DISC_IDLE_RST;
      night_thr   = ipsp_pkg::OVERNIGHT_SLEEP_RST;
      mode        = ipsp_pkg::MODE_ACTIVE;
      blockers    = '0;
      last_act    = '0;
      link_up     = 1'b0;
      audio_save  = 1'b0;
      low_power   = 1'b0;
      adv_low     = 1'b0;
      sleep_cnt   = '0;
      last_reason = ipsp_pkg::REASON_NONE;
    endfunction

    function void write_reg(ipsp_pkg::cfg_idx_e idx, logic [ipsp_pkg::TIME_W-1:0] val);
      case (idx)
        ipsp_pkg::CFG_OVERNIGHT_EN: guard_en = val[0];
        ipsp_pkg::CFG_AUDIO_IDLE:   audio_thr = val;
        ipsp_pkg::CFG_CONN_IDLE:    conn_thr = val;
        ipsp_pkg::CFG_DISC_IDLE:    disc_thr = val;
        ipsp_pkg::CFG_OVERNIGHT_MS: night_thr = val;
        ipsp_pkg::CFG_WAKE_PIN_OK:  wake_ok = val[0];
        default: ;
      endcase
    endfunction

    function ipsp_pkg::mode_e target(logic [ipsp_pkg::TIME_W-1:0] idle);
      if (blockers != '0) return ipsp_pkg::MODE_ACTIVE;
      if (guard_en && idle >= night_thr) return ipsp_pkg::MODE_OVERNIGHT;
      if (link_up) begin
        if (idle >= conn_thr) return ipsp_pkg::MODE_CONN_IDLE;
        return ipsp_pkg::MODE_ACTIVE;
      end
      if (idle >= disc_thr) return ipsp_pkg::MODE_DISC_IDLE;
      return ipsp_pkg::MODE_ACTIVE;
    endfunction

    function void set_flags(ipsp_pkg::mode_e st);
      audio_save = (st != ipsp_pkg::MODE_ACTIVE);
      low_power  = (st != ipsp_pkg::MODE_ACTIVE);
      adv_low    = (st == ipsp_pkg::MODE_DISC_IDLE) || (st == ipsp_pkg::MODE_OVERNIGHT);
    endfunction

    // Refusal causes are checked in priority order: guard, blockers, audio, wake pin.
    function ipsp_pkg::reject_e attempt_sleep(ipsp_pkg::reason_e why, logic audio);
      if (!guard_en) return ipsp_pkg::REJ_DISABLED;
      if (blockers != '0) return ipsp_pkg::REJ_BLOCKERS;
      if (audio) return ipsp_pkg::REJ_AUDIO;
      if (!wake_ok) return ipsp_pkg::REJ_NO_WAKE;
      last_reason = why;
      sleep_cnt   = sleep_cnt + 1;
      return ipsp_pkg::REJ_NONE;
    endfunction

    function void mark_activity(logic [ipsp_pkg::TIME_W-1:0] now);
      ipsp_pkg::mode_e prev;
      prev     = mode;
      last_act = now;
      mode     = ipsp_pkg::MODE_ACTIVE;
      if (prev != ipsp_pkg::MODE_ACTIVE) set_flags(ipsp_pkg::MODE_ACTIVE);
      else audio_save = 1'b0;
    endfunction

    function void predict_event(ipsp_pkg::in_item_t it);
      ipsp_pkg::mode_e             prior;
      ipsp_pkg::mode_e             nxt;
      logic [ipsp_pkg::TIME_W-1:0] idle;
      logic                        entered;
      ipsp_pkg::reject_e           rej;
      ipsp_pkg::result_t           r;
      prior   = mode;
      entered = 1'b0;
      rej     = ipsp_pkg::REJ_NONE;
      case (it.opcode)
        ipsp_pkg::OP_EVAL: begin
          // a link change restarts the idle timer and forces active first
          if (link_up != it.link_connected) begin
            link_up  = it.link_connected;
            last_act = it.now_ms;
            mode     = ipsp_pkg::MODE_ACTIVE;
          end
          idle = it.now_ms - last_act;
          nxt  = target(idle);
          if (prior != nxt) begin
            mode = nxt;
            set_flags(nxt);
          end
          if (nxt == ipsp_pkg::MODE_ACTIVE)
            audio_save = (blockers == '0) && (idle >= audio_thr);
          if (nxt == ipsp_pkg::MODE_OVERNIGHT) begin
            rej = attempt_sleep(ipsp_pkg::REASON_OVERNIGHT, it.audio_session_active);
            if (rej != ipsp_pkg::REJ_NONE) begin
              last_act = it.now_ms;
              if (link_up) mode = ipsp_pkg::MODE_CONN_IDLE;
              else mode = ipsp_pkg::MODE_DISC_IDLE;
            end else begin
              entered = 1'b1;
            end
          end
        end
        ipsp_pkg::OP_ACTIVITY: mark_activity(it.now_ms);
        ipsp_pkg::OP_SET_BLK, ipsp_pkg::OP_CLR_BLK: begin
          if (it.blk_mask != '0) begin
            if (it.opcode == ipsp_pkg::OP_SET_BLK) blockers = blockers | it.blk_mask;
            else blockers = blockers & ~it.blk_mask;
            last_act = it.now_ms;
            if (blockers != '0 && mode != ipsp_pkg::MODE_ACTIVE) begin
              mode = ipsp_pkg::MODE_ACTIVE;
              set_flags(ipsp_pkg::MODE_ACTIVE);
            end else if (blockers != '0) begin
              audio_save = 1'b0;
            end
          end
        end
        ipsp_pkg::OP_LINK: begin
          link_up  = it.link_connected;
          last_act = it.now_ms;
          mode     = ipsp_pkg::MODE_ACTIVE;
          set_flags(ipsp_pkg::MODE_ACTIVE);
        end
        ipsp_pkg::OP_SLEEP_REQ: begin
          mark_activity(it.now_ms);
          rej     = attempt_sleep(ipsp_pkg::REASON_MANUAL, it.audio_session_active);
          entered = (rej == ipsp_pkg::REJ_NONE);
        end
        default: ;
      endcase
      r.power_state           = mode;
      r.state_changed         = (mode != prior);
      r.idle_ms               = it.now_ms - last_act;
      r.audio_power_save      = audio_save;
      r.low_power_mode        = low_power;
      r.low_power_advertising = adv_low;
      r.sleep_entered         = entered;
      r.reject_cause          = rej;
      expected_results.push_back(r);
    endfunction

    function void check_result(ipsp_pkg::result_t got);
      ipsp_pkg::result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result with nothing pending: state %0d idle %0d",
                                   $time, got.power_state, got.idle_ms);
        return;
      end
      want = expected_results.pop_front();
      if (got.power_state !== want.power_state || got.state_changed !== want.state_changed ||
          got.idle_ms !== want.idle_ms || got.audio_power_save !== want.audio_power_save ||
          got.low_power_mode !== want.low_power_mode ||
          got.low_power_advertising !== want.low_power_advertising ||
          got.sleep_entered !== want.sleep_entered || got.reject_cause !== want.reject_cause)
      begin
        errors++;
        if (errors <= 10) begin
          $display({"%0t: mismatch exp state %0d chg %0d idle %0d asave %0d",
                    " lp %0d adv %0d slp %0d rej %0d"},
                   $time, want.power_state, want.state_changed, want.idle_ms,
                   want.audio_power_save, want.low_power_mode, want.low_power_advertising,
                   want.sleep_entered, want.reject_cause);
          $display({"%0t:          got state %0d chg %0d idle %0d asave %0d",
                    " lp %0d adv %0d slp %0d rej %0d"},
                   $time, got.power_state, got.state_changed, got.idle_ms,
                   got.audio_power_save, got.low_power_mode, got.low_power_advertising,
                   got.sleep_entered, got.reject_cause);
        end
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [ipsp_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [ipsp_pkg::TIME_W-1:0]    cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [2:0]                     opcode_i = '0;
  logic [ipsp_pkg::TIME_W-1:0]    now_ms_i = '0;
  logic [ipsp_pkg::MASK_W-1:0]    blk_mask_i = '0;
  logic                           link_connected_i = 1'b0;
  logic                           audio_session_active_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [1:0]                     power_state_o;
  logic                           state_changed_o;
  logic [ipsp_pkg::TIME_W-1:0]    idle_ms_o;
  logic                           audio_power_save_o;
  logic                           low_power_mode_o;
  logic                           low_power_advertising_o;
  logic                           sleep_entered_o;
  logic [2:0]                     reject_cause_o;

  policy_tracker               sb;
  ipsp_pkg::result_t           seen;
  logic [ipsp_pkg::TIME_W-1:0] clock_ms = '0;
  logic                        link_level = 1'b0;
  bit                          quiet = 1'b0;
  bit                          hold_request = 1'b0;
  int                          stuck_cycles = 0;

  idle_power_state_policy DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .opcode_i               (opcode_i),
    .now_ms_i               (now_ms_i),
    .blk_mask_i             (blk_mask_i),
    .link_connected_i       (link_connected_i),
    .audio_session_active_i (audio_session_active_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .power_state_o          (power_state_o),
    .state_changed_o        (state_changed_o),
    .idle_ms_o              (idle_ms_o),
    .audio_power_save_o     (audio_power_save_o),
    .low_power_mode_o       (low_power_mode_o),
    .low_power_advertising_o(low_power_advertising_o),
    .sleep_entered_o        (sleep_entered_o),
    .reject_cause_o         (reject_cause_o)
  );

  always #5ns clk_i = ~clk_i;

  // Entered at a falling edge; returns at the falling edge after acceptance with valid still high.
  task automatic send_item(ipsp_pkg::in_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i             <= 1'b1;
    opcode_i               <= it.opcode;
    now_ms_i               <= it.now_ms;
    blk_mask_i             <= it.blk_mask;
    link_connected_i       <= it.link_connected;
    audio_session_active_i <= it.audio_session_active;
    do @(posedge clk_i); while (in_stall_o);
    sb.predict_event(it);
    @(negedge clk_i);
  endtask

  task automatic offer(logic [2:0] op, logic [ipsp_pkg::TIME_W-1:0] now,
                       logic [ipsp_pkg::MASK_W-1:0] mask, logic link, logic audio);
    ipsp_pkg::in_item_t it;
    it.opcode               = op;
    it.now_ms               = now;
    it.blk_mask             = mask;
    it.link_connected       = link;
    it.audio_session_active = audio;
    send_item(it);
  endtask

  // Drop valid and wait until every pending result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(ipsp_pkg::cfg_idx_e idx, logic [ipsp_pkg::TIME_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic configure(logic en, logic [ipsp_pkg::TIME_W-1:0] audio_ms,
                           logic [ipsp_pkg::TIME_W-1:0] conn_ms,
                           logic [ipsp_pkg::TIME_W-1:0] disc_ms,
                           logic [ipsp_pkg::TIME_W-1:0] night_ms, logic wake);
    drain();
    write_reg(ipsp_pkg::CFG_OVERNIGHT_EN, {31'd0, en});
    write_reg(ipsp_pkg::CFG_AUDIO_IDLE, audio_ms);
    write_reg(ipsp_pkg::CFG_CONN_IDLE, conn_ms);
    write_reg(ipsp_pkg::CFG_DISC_IDLE, disc_ms);
    write_reg(ipsp_pkg::CFG_OVERNIGHT_MS, night_ms);
    write_reg(ipsp_pkg::CFG_WAKE_PIN_OK, {31'd0, wake});
    cfg_we_i <= 1'b0;
  endtask

  // Time advances by a random step per event, with occasional jumps anywhere in the range.
  task automatic run_phase(int count, int unsigned step_max, bit squeeze);
    ipsp_pkg::in_item_t it;
    int done;
    int tries;
    int pick;
    int sel;
    done  = 0;
    tries = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 15) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      if ($urandom_range(0, 5) == 0) link_level = ~link_level;
      it.now_ms               = clock_ms;
      it.link_connected       = link_level;
      it.audio_session_active = ($urandom_range(0, 3) == 0);
      it.blk_mask             = 8'($urandom);
      if (pick < 40) begin
        it.opcode = ipsp_pkg::OP_EVAL;
      end else if (pick < 50) begin
        it.opcode = ipsp_pkg::OP_ACTIVITY;
      end else if (pick < 58) begin
        it.opcode = ipsp_pkg::OP_SET_BLK;
        if ($urandom_range(0, 9) == 0) it.blk_mask = '0;
        else it.blk_mask = 8'($urandom_range(1, 255));
      end else if (pick < 68) begin
        it.opcode = ipsp_pkg::OP_CLR_BLK;
        sel = $urandom_range(0, 9);
        if (sel < 6) it.blk_mask = 8'hFF;
        else if (sel == 9) it.blk_mask = '0;
      end else if (pick < 76) begin
        it.opcode = ipsp_pkg::OP_LINK;
      end else if (pick < 88) begin
        it.opcode = ipsp_pkg::OP_SLEEP_REQ;
      end else if (pick < 94) begin
        it.opcode = ($urandom_range(0, 1) != 0) ? OP_UNUSED_HI : OP_UNUSED_LO;
      end else begin
        it.opcode = ipsp_pkg::OP_EVAL;
      end
      if (it.opcode != OP_UNUSED_LO && it.opcode != OP_UNUSED_HI &&
          !((it.opcode == ipsp_pkg::OP_SET_BLK || it.opcode == ipsp_pkg::OP_CLR_BLK) &&
            it.blk_mask == '0))
        done++;
      if (squeeze && tries == 20) hold_request = 1'b1;
      tries++;
      send_item(it);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none in the quiet part.
  initial begin
    int len;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 9) < 2) begin
        len = $urandom_range(1, 19);
        out_stall_i <= 1'b1;
        repeat (len - 1) @(negedge clk_i);
      end else begin
        len = $urandom_range(1, 12);
        out_stall_i <= 1'b0;
        repeat (len - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.power_state           = ipsp_pkg::mode_e'(power_state_o);
      seen.state_changed         = state_changed_o;
      seen.idle_ms               = idle_ms_o;
      seen.audio_power_save      = audio_power_save_o;
      seen.low_power_mode        = low_power_mode_o;
      seen.low_power_advertising = low_power_advertising_o;
      seen.sleep_entered         = sleep_entered_o;
      seen.reject_cause          = reject_cause_o;
      sb.check_result(seen);
    end
  end

  // Abort when neither side moves an item for too long.
  initial begin
    while (stuck_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    sb = new();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: idle thresholds, link changes, blockers, sleep paths and wrap
    offer(ipsp_pkg::OP_EVAL,      32'd0,        8'h00, 1'b0, 1'b0);
    offer(ipsp_pkg::OP_EVAL,      32'd5000,     8'h00, 1'b0, 1'b0);
    offer(ipsp_pkg::OP_EVAL,      32'd30000,    8'h00, 1'b0, 1'b0);
    offer(ipsp_pkg::OP_EVAL,      32'd30001,    8'h00, 1'b1, 1'b0);
    offer(ipsp_pkg::OP_EVAL,      32'd60001,    8'h00, 1'b1, 1'b0);
    offer(ipsp_pkg::OP_SET_BLK,   32'd60002,    8'h00, 1'b1, 1'b0);
    offer(ipsp_pkg::OP_SET_BLK,   32'd60003,    8'hA5, 1'b1, 1'b0);
    offer(ipsp_pkg::OP_EVAL,      32'd2000000,  8'h5A, 1'b1, 1'b1);
    offer(ipsp_pkg::OP_SLEEP_REQ, 32'd2000001,  8'h00, 1'b1, 1'b0);
    offer(ipsp_pkg::OP_CLR_BLK,   32'd2000002,  8'h00, 1'b1, 1'b0);
    offer(ipsp_pkg::OP_CLR_BLK,   32'd2000003,  8'hFF, 1'b1, 1'b0);
    offer(ipsp_pkg::OP_SLEEP_REQ, 32'd2000004,  8'h00, 1'b1, 1'b1);
    offer(ipsp_pkg::OP_SLEEP_REQ, 32'd2000005,  8'h00, 1'b1, 1'b0);
    offer(ipsp_pkg::OP_EVAL,      32'd3800005,  8'h00, 1'b1, 1'b1);
    offer(ipsp_pkg::OP_EVAL,      32'd5600005,  8'h00, 1'b1, 1'b0);
    offer(ipsp_pkg::OP_EVAL,      32'd5600006,  8'h00, 1'b1, 1'b0);
    offer(ipsp_pkg::OP_ACTIVITY,  32'd5600010,  8'hFF, 1'b1, 1'b1);
    offer(ipsp_pkg::OP_LINK,      32'd5600020,  8'h00, 1'b0, 1'b0);
    offer(OP_UNUSED_LO,           32'hFFFF0000, 8'hFF, 1'b1, 1'b1);
    offer(OP_UNUSED_HI,           32'h0000FFFF, 8'hFF, 1'b0, 1'b0);
    offer(ipsp_pkg::OP_EVAL,      32'hFFFFFFFF, 8'h00, 1'b0, 1'b1);
    offer(ipsp_pkg::OP_ACTIVITY,  32'hFFFFFFFF, 8'h00, 1'b0, 1'b0);
    offer(ipsp_pkg::OP_EVAL,      32'h00000010, 8'h00, 1'b0, 1'b0);
    offer(ipsp_pkg::OP_SET_BLK,   32'h80000000, 8'hFF, 1'b1, 1'b1);
    offer(ipsp_pkg::OP_CLR_BLK,   32'h80000001, 8'h0F, 1'b1, 1'b1);

    clock_ms = 32'hFFFFFF00;
    configure(1'b1, 32'd10, 32'd40, 32'd60, 32'd150, 1'b1);
    run_phase(72, 12, 1'b1);
    configure(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
    run_phase(72, 8, 1'b0);
    configure(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
    run_phase(72, 32'h40000000, 1'b0);
    configure(1'b1, 32'd5, 32'd20, 32'd30, 32'd80, 1'b0);
    run_phase(72, 10, 1'b0);
    configure(1'b1, 32'd0, 32'd100, 32'd20, 32'd0, 1'b1);
    run_phase(72, 6, 1'b0);
    configure(1'($urandom_range(0, 1)), $urandom_range(0, 200), $urandom_range(0, 200),
              $urandom_range(0, 200), $urandom_range(0, 400), 1'($urandom_range(0, 1)));
    run_phase(72, 25, 1'b0);
    configure(1'b1, $urandom, $urandom, $urandom, $urandom, 1'b1);
    run_phase(72, $urandom_range(1, 32'h7FFFFFFF), 1'b0);
    configure(1'b1, ipsp_pkg::AUDIO_IDLE_RST, ipsp_pkg::CONN_IDLE_RST,
              ipsp_pkg::DISC_IDLE_RST, ipsp_pkg::OVERNIGHT_SLEEP_RST, 1'b1);
    quiet = 1'b1;
    run_phase(72, 60000, 1'b0);
    drain();

    repeat (5) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: idle_power_state_policy.f
rtl/ipsp_pkg.sv
rtl/ipsp_cfg_regs.sv
rtl/ipsp_step.sv
rtl/idle_power_state_policy.sv
rtl/ipsp_checker.sv
test/tb_idle_power_state_policy.sv
